// ===== hw/rtl/dynamic_supercut_classifier_assert.svh =====
`ifndef DYNAMIC_SUPERCUT_CLASSIFIER_ASSERT_SVH
`define DYNAMIC_SUPERCUT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define DSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define DSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dsc_pkg.sv =====
package dsc_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int COEFS_PER_LIMIT = 8;
  localparam int NUM_LIMITS      = 14;
  localparam int TABLE_DEPTH     = NUM_LIMITS * COEFS_PER_LIMIT;
  localparam int PTR_W           = $clog2(TABLE_DEPTH);
  localparam int NUM_TESTS       = 7;
  localparam int VAL_W           = 39;
  localparam int SH_W            = 5;
  localparam int PROD_LIM_BITS   = 62;
  localparam int Q30_TO_FRAC     = 30 - FRAC_BITS;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [VAL_W:0]   wide_t;

  localparam val_t  SAT_MAG          = val_t'(64'sd137438953471);
  localparam val_t  LN2_Q30          = val_t'(64'sd744261118);
  localparam wide_t NOM_LOG_SIZE_Q30 = wide_t'(64'sd4402341478);
  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [23:0] MM_TO_DEG_RST = 24'd52429;

  localparam logic [SH_W-1:0] SH_TRIG  = SH_W'(30);
  localparam logic [SH_W-1:0] SH_SCALE = SH_W'(24);
  localparam logic [SH_W-1:0] SH_FRAC  = SH_W'(FRAC_BITS);
  localparam logic [SH_W-1:0] SH_NONE  = SH_W'(0);

  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  localparam logic REG_MM_TO_DEG = 1'b0;

  typedef struct packed {
    logic            start;
    val_t            a;
    val_t            b;
    logic [SH_W-1:0] sh;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    val_t        res;
    logic [63:0] raw;
  } mul_rsp_t;

  function automatic val_t sat_add(input val_t x, input val_t y);
    wide_t s;
    s = wide_t'(x) + wide_t'(y);
    if (s > wide_t'(SAT_MAG)) return SAT_MAG;
    else if (s < -wide_t'(SAT_MAG)) return -SAT_MAG;
    else return val_t'(s);
  endfunction

  // Horner coefficients of cos(x) - 1 in x^2, Q30, highest order first after the seed.
  function automatic val_t cos_coef(input logic [2:0] k);
    case (k)
      3'd0:    return val_t'(-296);
      3'd1:    return val_t'(26631);
      3'd2:    return val_t'(-1491308);
      3'd3:    return val_t'(44739243);
      3'd4:    return val_t'(-536870912);
      default: return '0;
    endcase
  endfunction

  // Cut variable whose limits serve each test; the centroid distance uses distance limits.
  function automatic logic [2:0] test_var(input logic [2:0] j);
    case (j)
      3'd0:    return 3'd0;
      3'd1:    return 3'd1;
      3'd2:    return 3'd2;
      3'd3:    return 3'd3;
      3'd4:    return 3'd0;
      3'd5:    return 3'd5;
      3'd6:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/dsc_mul.sv =====
module dsc_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_pkg::mul_req_t req,
  output dsc_pkg::mul_rsp_t rsp
);

  localparam int MAG_W  = dsc_pkg::VAL_W - 1;
  localparam int HALF   = MAG_W / 2;
  localparam int PART_W = MAG_W + HALF;
  localparam int PROD_W = 2 * MAG_W;
  localparam logic [PROD_W-1:0] SAT_U = PROD_W'(dsc_pkg::SAT_MAG);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]              ph_r;
  logic                    done_r;
  logic [MAG_W-1:0]        ua_r, ub_r;
  logic                    neg_r;
  logic [dsc_pkg::SH_W-1:0] sh_r;
  logic [PART_W-1:0]       plo_r, phi_r;
  dsc_pkg::val_t           res_r;
  logic [63:0]             raw_r;

  logic [PROD_W-1:0] prod, rnd, q;
  logic              big;
  dsc_pkg::val_t     qmag, res_c;

  // Assemble the product, floor it by the shift and saturate the magnitude.
  always_comb begin
    prod = PROD_W'(plo_r) + (PROD_W'(phi_r) << HALF);
    big  = |prod[PROD_W-1:dsc_pkg::PROD_LIM_BITS];
    rnd  = neg_r ? ((PROD_W'(1) << sh_r) - PROD_W'(1)) : '0;
    q    = (prod + rnd) >> sh_r;
    if (big || (q > SAT_U)) qmag = dsc_pkg::SAT_MAG;
    else qmag = dsc_pkg::val_t'(q[dsc_pkg::VAL_W-1:0]);
    res_c = neg_r ? -qmag : qmag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            ua_r  <= req.a[dsc_pkg::VAL_W-1] ? MAG_W'(-req.a) : MAG_W'(req.a);
            ub_r  <= req.b[dsc_pkg::VAL_W-1] ? MAG_W'(-req.b) : MAG_W'(req.b);
            neg_r <= req.a[dsc_pkg::VAL_W-1] ^ req.b[dsc_pkg::VAL_W-1];
            sh_r  <= req.sh;
            ph_r  <= PH_LO;
          end
        end
        PH_LO: begin
          plo_r <= PART_W'(ua_r) * PART_W'(ub_r[HALF-1:0]);
          ph_r  <= PH_HI;
        end
        PH_HI: begin
          phi_r <= PART_W'(ua_r) * PART_W'(ub_r[MAG_W-1:HALF]);
          ph_r  <= PH_FIN;
        end
        PH_FIN: begin
          res_r  <= res_c;
          raw_r  <= prod[63:0];
          done_r <= 1'b1;
          ph_r   <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.raw  = raw_r;

endmodule

// ===== hw/rtl/dynamic_supercut_classifier.sv =====
// Dynamic supercut classifier. A transaction is accepted when start is high and busy is
// low. A load transaction (in_opcode = 1) writes the next of the 112 cut coefficients,
// with the write pointer wrapping after the last entry; it gives no result and leaves
// busy low. A classify transaction gives exactly one result: out_is_hadron, shown for one
// cycle with out_strobe. The receiver cannot stall the block, so the result must be
// captured in that cycle. An event with zero size is a hadron and its result appears in
// the cycle after acceptance without raising busy. Any other event keeps busy high while
// it is processed, and its result appears in the cycle in which busy falls. Processing
// is paced by the single shared multiplier, which serves 146 products in turn (cosine
// series, 30 squarings of the logarithm, the log, centroid distance and scaling products
// and the 98 products of the 14 limit polynomials), plus the bit-serial square root and
// eight coefficient reads per limit through the one read port of the coefficient memory.
// A new transaction may be accepted while the previous result is on the outputs. The
// plate scale register sits at APB address 0 and must only be written while busy is low.
// Coefficient entries that were never loaded read as undefined values.

module dynamic_supercut_classifier (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic signed [31:0] in_coef_value,
  input  logic [16:0]        in_zenith_angle,
  input  logic [30:0]        in_image_width,
  input  logic [30:0]        in_image_length,
  input  logic [30:0]        in_image_size,
  input  logic signed [31:0] in_centroid_x,
  input  logic signed [31:0] in_centroid_y,
  input  logic [30:0]        in_source_distance,
  input  logic signed [31:0] in_signed_asymmetry,
  input  logic [16:0]        in_concentration,
  input  logic [16:0]        in_leakage,
  output logic               out_strobe,
  output logic               out_is_hadron,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_COS_X2 = 5'd1;
  localparam logic [4:0] S_COS_H  = 5'd2;
  localparam logic [4:0] S_COS_F  = 5'd3;
  localparam logic [4:0] S_LOG_SQ = 5'd4;
  localparam logic [4:0] S_LOG_A  = 5'd5;
  localparam logic [4:0] S_LOG_B  = 5'd6;
  localparam logic [4:0] S_LS2    = 5'd7;
  localparam logic [4:0] S_SQX    = 5'd8;
  localparam logic [4:0] S_SQY    = 5'd9;
  localparam logic [4:0] S_SQRT   = 5'd10;
  localparam logic [4:0] S_DIST   = 5'd11;
  localparam logic [4:0] S_DD2    = 5'd12;
  localparam logic [4:0] S_SCALE  = 5'd13;
  localparam logic [4:0] S_LIM_RD = 5'd14;
  localparam logic [4:0] S_LIM_MUL = 5'd15;

  localparam logic [63:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;

  // Control state.
  logic [4:0]                  state_r;
  logic                        wait_r;
  logic [dsc_pkg::PTR_W-1:0]   ptr_r;
  logic                        out_strobe_r;
  logic                        hadron_r;
  logic [23:0]                 mm_r;

  // Coefficient store, single write port and one registered read port.
  logic [31:0]                 coef_mem [dsc_pkg::TABLE_DEPTH];
  logic [31:0]                 rd_q_r;
  logic [dsc_pkg::PTR_W-1:0]   rd_addr;

  // Event datapath registers.
  logic [30:0]                 x30_r;
  logic [4:0]                  e_r;
  logic [30:0]                 m_r;
  logic [29:0]                 frac_r;
  logic [31:0]                 ux_r, uy_r;
  dsc_pkg::val_t               x2_r, p_r, ct_r, t_r, ls_r, ls2_r, dd2_r;
  dsc_pkg::val_t               acc_r, base_r, mid_r;
  dsc_pkg::val_t               raw_in_r [4];
  dsc_pkg::val_t               val_r [dsc_pkg::NUM_TESTS];
  logic [31:0]                 coef_r [dsc_pkg::COEFS_PER_LIMIT];
  logic [63:0]                 sq_r, rem_r, root_r, bit_r;
  logic [2:0]                  k_r;
  logic [4:0]                  cnt_r;
  logic [1:0]                  j_r;
  logic [2:0]                  tj_r;
  logic                        side_r;
  logic [3:0]                  c_r;
  logic [2:0]                  t_r2;
  logic                        pass_r;

  dsc_pkg::mul_req_t           mul_req;
  dsc_pkg::mul_rsp_t           mul_rsp;

  logic                        accept, ld_acc, cfg_wr;
  logic [4:0]                  e_c;
  logic [38:0]                 zx;
  logic [30:0]                 x30_c;
  logic                        mul_use;
  dsc_pkg::val_t               op_a, op_b, addend, sum;
  logic [dsc_pkg::SH_W-1:0]    op_sh;
  dsc_pkg::wide_t              ln_diff;
  logic [63:0]                 trial;
  logic                        cmp_ok;
  logic [3:0]                  lim_idx;

  assign accept = start && !busy;
  assign ld_acc = accept && (in_opcode == dsc_pkg::OP_LOAD);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dsc_pkg::REG_MM_TO_DEG) ? {8'd0, mm_r} : 32'd0;

  assign out_strobe    = out_strobe_r;
  assign out_is_hadron = hadron_r;

  // Leading-one position of the size sets the integer part of log2.
  always_comb begin
    e_c = '0;
    for (int i = 0; i < 31; i++) begin
      if (in_image_size[i]) e_c = 5'(i);
    end
  end

  // Zenith angle moved to Q30 and limited to pi/2.
  always_comb begin
    zx    = 39'(in_zenith_angle) << dsc_pkg::Q30_TO_FRAC;
    x30_c = (zx > 39'(dsc_pkg::HALF_PI_Q30)) ? dsc_pkg::HALF_PI_Q30 : zx[30:0];
  end

  // The limit being evaluated: upper limit of the test's variable first, then the lower.
  assign lim_idx = {dsc_pkg::test_var(tj_r), side_r};
  assign rd_addr = dsc_pkg::PTR_W'(32'(lim_idx) * dsc_pkg::COEFS_PER_LIMIT)
                 + dsc_pkg::PTR_W'(c_r[2:0]);

  // Operand selection for the shared multiplier and the addend of the following sum.
  always_comb begin
    mul_use = 1'b1;
    op_a    = '0;
    op_b    = '0;
    op_sh   = dsc_pkg::SH_NONE;
    addend  = '0;
    case (state_r)
      S_COS_X2: begin
        op_a  = dsc_pkg::val_t'(x30_r);
        op_b  = dsc_pkg::val_t'(x30_r);
        op_sh = dsc_pkg::SH_TRIG;
      end
      S_COS_H, S_COS_F: begin
        op_a  = p_r;
        op_b  = x2_r;
        op_sh = dsc_pkg::SH_TRIG;
      end
      S_LOG_SQ: begin
        op_a  = dsc_pkg::val_t'(m_r);
        op_b  = dsc_pkg::val_t'(m_r);
        op_sh = dsc_pkg::SH_TRIG;
      end
      S_LOG_A: begin
        op_a  = dsc_pkg::val_t'(frac_r);
        op_b  = dsc_pkg::LN2_Q30;
        op_sh = dsc_pkg::SH_TRIG;
      end
      S_LOG_B: begin
        op_a  = dsc_pkg::val_t'(e_r) - dsc_pkg::val_t'(dsc_pkg::FRAC_BITS);
        op_b  = dsc_pkg::LN2_Q30;
        op_sh = dsc_pkg::SH_NONE;
      end
      S_LS2: begin
        op_a  = ls_r;
        op_b  = ls_r;
        op_sh = dsc_pkg::SH_FRAC;
      end
      S_SQX: begin
        op_a = dsc_pkg::val_t'(ux_r);
        op_b = dsc_pkg::val_t'(ux_r);
      end
      S_SQY: begin
        op_a = dsc_pkg::val_t'(uy_r);
        op_b = dsc_pkg::val_t'(uy_r);
      end
      S_DIST: begin
        op_a  = dsc_pkg::val_t'(root_r[32:0]);
        op_b  = dsc_pkg::val_t'(mm_r);
        op_sh = dsc_pkg::SH_SCALE;
      end
      S_DD2: begin
        op_a  = val_r[4];
        op_b  = val_r[4];
        op_sh = dsc_pkg::SH_FRAC;
      end
      S_SCALE: begin
        op_a  = raw_in_r[j_r];
        op_b  = dsc_pkg::val_t'(mm_r);
        op_sh = dsc_pkg::SH_SCALE;
      end
      S_LIM_MUL: begin
        op_sh = dsc_pkg::SH_FRAC;
        case (t_r2)
          3'd0: begin
            op_a = dsc_pkg::val_t'(signed'(coef_r[1])); op_b = dd2_r;
            addend = dsc_pkg::val_t'(signed'(coef_r[0]));
          end
          3'd1: begin
            op_a = dsc_pkg::val_t'(signed'(coef_r[2])); op_b = ct_r; addend = acc_r;
          end
          3'd2: begin
            op_a = dsc_pkg::val_t'(signed'(coef_r[4])); op_b = dd2_r;
            addend = dsc_pkg::val_t'(signed'(coef_r[3]));
          end
          3'd3: begin
            op_a = dsc_pkg::val_t'(signed'(coef_r[5])); op_b = ct_r; addend = acc_r;
          end
          3'd4: begin
            op_a = dsc_pkg::val_t'(signed'(coef_r[7])); op_b = dd2_r;
            addend = dsc_pkg::val_t'(signed'(coef_r[6]));
          end
          3'd5: begin
            op_a = ls_r; op_b = mid_r; addend = base_r;
          end
          3'd6: begin
            op_a = ls2_r; op_b = acc_r; addend = p_r;
          end
          default: ;
        endcase
      end
      default: mul_use = 1'b0;
    endcase
    mul_req.start = mul_use && !wait_r;
    mul_req.a     = op_a;
    mul_req.b     = op_b;
    mul_req.sh    = op_sh;
  end

  assign sum = dsc_pkg::sat_add(addend, mul_rsp.res);

  // ln(size) - 4.1 in Q30, floored to the working fraction width.
  assign ln_diff = dsc_pkg::wide_t'(mul_rsp.res) + dsc_pkg::wide_t'(t_r)
                 - dsc_pkg::NOM_LOG_SIZE_Q30;

  assign trial  = root_r + bit_r;
  assign cmp_ok = side_r ? (val_r[tj_r] > sum) : (val_r[tj_r] < sum);

  dsc_mul u_mul (
    .clk (clk),
    .rst_n (rst_n),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (ld_acc) coef_mem[ptr_r] <= in_coef_value;
    rd_q_r <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wait_r       <= 1'b0;
      ptr_r        <= '0;
      out_strobe_r <= 1'b0;
      mm_r         <= dsc_pkg::MM_TO_DEG_RST;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_wr && (paddr[2] == dsc_pkg::REG_MM_TO_DEG)) mm_r <= pwdata[23:0];
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_opcode == dsc_pkg::OP_LOAD) begin
              ptr_r <= (ptr_r == dsc_pkg::PTR_W'(dsc_pkg::TABLE_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
            end else if (in_image_size == 31'd0) begin
              // The logarithm of a zero size is undefined: classify as hadron at once.
              out_strobe_r <= 1'b1;
              hadron_r     <= 1'b1;
            end else begin
              x30_r       <= x30_c;
              e_r         <= e_c;
              m_r         <= in_image_size << (5'd30 - e_c);
              frac_r      <= '0;
              ux_r        <= in_centroid_x[31] ? 32'(-in_centroid_x) : in_centroid_x;
              uy_r        <= in_centroid_y[31] ? 32'(-in_centroid_y) : in_centroid_y;
              raw_in_r[0] <= dsc_pkg::val_t'(in_source_distance);
              raw_in_r[1] <= dsc_pkg::val_t'(in_image_length);
              raw_in_r[2] <= dsc_pkg::val_t'(in_image_width);
              raw_in_r[3] <= dsc_pkg::val_t'(in_signed_asymmetry);
              val_r[5]    <= dsc_pkg::val_t'(in_concentration);
              val_r[6]    <= dsc_pkg::val_t'(in_leakage);
              wait_r      <= 1'b0;
              state_r     <= S_COS_X2;
            end
          end
        end
        S_SQRT: begin
          // One result bit per cycle of the integer square root.
          if (rem_r >= trial) begin
            rem_r  <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) state_r <= S_DIST;
        end
        S_LIM_RD: begin
          // Eight reads of the limit's coefficients; data lands in the cycle after its address.
          if (c_r != 4'd0) coef_r[3'(c_r - 4'd1)] <= rd_q_r;
          c_r <= c_r + 1'b1;
          if (c_r == 4'(dsc_pkg::COEFS_PER_LIMIT)) begin
            t_r2    <= '0;
            state_r <= S_LIM_MUL;
          end
        end
        default: begin
          if (mul_use) begin
            if (!wait_r) begin
              wait_r <= 1'b1;
            end else if (mul_rsp.done) begin
              wait_r <= 1'b0;
              case (state_r)
                S_COS_X2: begin
                  x2_r    <= mul_rsp.res;
                  p_r     <= dsc_pkg::val_t'(2);
                  k_r     <= '0;
                  state_r <= S_COS_H;
                end
                S_COS_H: begin
                  p_r <= dsc_pkg::sat_add(dsc_pkg::cos_coef(k_r), mul_rsp.res);
                  k_r <= k_r + 1'b1;
                  if (k_r == 3'd4) state_r <= S_COS_F;
                end
                S_COS_F: begin
                  ct_r    <= mul_rsp.res >>> dsc_pkg::Q30_TO_FRAC;
                  cnt_r   <= '0;
                  state_r <= S_LOG_SQ;
                end
                S_LOG_SQ: begin
                  // Square the mantissa; a carry into bit 31 is the next fraction bit.
                  if (mul_rsp.res[31]) begin
                    m_r    <= mul_rsp.res[31:1];
                    frac_r <= {frac_r[28:0], 1'b1};
                  end else begin
                    m_r    <= mul_rsp.res[30:0];
                    frac_r <= {frac_r[28:0], 1'b0};
                  end
                  cnt_r <= cnt_r + 1'b1;
                  if (cnt_r == 5'd29) state_r <= S_LOG_A;
                end
                S_LOG_A: begin
                  t_r     <= mul_rsp.res;
                  state_r <= S_LOG_B;
                end
                S_LOG_B: begin
                  ls_r    <= dsc_pkg::val_t'(ln_diff >>> dsc_pkg::Q30_TO_FRAC);
                  state_r <= S_LS2;
                end
                S_LS2: begin
                  ls2_r   <= mul_rsp.res;
                  state_r <= S_SQX;
                end
                S_SQX: begin
                  sq_r    <= mul_rsp.raw;
                  state_r <= S_SQY;
                end
                S_SQY: begin
                  rem_r   <= sq_r + mul_rsp.raw;
                  root_r  <= '0;
                  bit_r   <= ROOT_BIT0;
                  cnt_r   <= '0;
                  state_r <= S_SQRT;
                end
                S_DIST: begin
                  val_r[4] <= mul_rsp.res;
                  state_r  <= S_DD2;
                end
                S_DD2: begin
                  dd2_r   <= mul_rsp.res;
                  j_r     <= '0;
                  state_r <= S_SCALE;
                end
                S_SCALE: begin
                  val_r[3'(j_r)] <= mul_rsp.res;
                  j_r <= j_r + 1'b1;
                  if (j_r == 2'd3) begin
                    tj_r    <= '0;
                    side_r  <= 1'b0;
                    c_r     <= '0;
                    pass_r  <= 1'b1;
                    state_r <= S_LIM_RD;
                  end
                end
                S_LIM_MUL: begin
                  // Polynomial steps: base, middle and high terms, then the two ls products.
                  t_r2 <= t_r2 + 1'b1;
                  case (t_r2)
                    3'd0: acc_r  <= sum;
                    3'd1: base_r <= sum;
                    3'd2: acc_r  <= sum;
                    3'd3: mid_r  <= sum;
                    3'd4: acc_r  <= sum;
                    3'd5: p_r    <= sum;
                    3'd6: begin
                      c_r <= '0;
                      if (!side_r) begin
                        pass_r  <= pass_r && cmp_ok;
                        side_r  <= 1'b1;
                        state_r <= S_LIM_RD;
                      end else if (tj_r == 3'(dsc_pkg::NUM_TESTS - 1)) begin
                        out_strobe_r <= 1'b1;
                        hadron_r     <= !(pass_r && cmp_ok);
                        state_r      <= S_IDLE;
                      end else begin
                        pass_r  <= pass_r && cmp_ok;
                        side_r  <= 1'b0;
                        tj_r    <= tj_r + 1'b1;
                        state_r <= S_LIM_RD;
                      end
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/dsc_checker.sv =====
`include "dynamic_supercut_classifier_assert.svh"

module dsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_opcode,
  input logic [30:0] in_image_size,
  input logic        out_strobe,
  input logic        out_is_hadron
);

  `DSC_ASSERT_NEXT(a_zero_size_hadron, start && !busy && (in_opcode == dsc_pkg::OP_CLASSIFY) && (in_image_size == 31'd0), out_strobe && out_is_hadron && !busy, "zero size event did not give a hadron result")
  `DSC_ASSERT_NEXT(a_load_silent, start && !busy && (in_opcode == dsc_pkg::OP_LOAD), !out_strobe && !busy, "load transaction produced a result or raised busy")
  `DSC_ASSERT_NEXT(a_event_busy, start && !busy && (in_opcode == dsc_pkg::OP_CLASSIFY) && (in_image_size != 31'd0), busy && !out_strobe, "event did not enter processing")
  `DSC_ASSERT_SAME(a_done_strobe, $fell(busy), out_strobe, "event finished without a result strobe")

endmodule

bind dynamic_supercut_classifier dsc_checker u_dsc_checker (.*);
